>>> hdl/ltp_pkg.sv
package ltp_pkg;

  localparam int ENTRIES     = 64;
  localparam int TICKET_BITS = 10;

  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int SUM_BITS  = $clog2(ENTRIES * ((1 << TICKET_BITS) - 1) + 1);
  localparam int CMP_BITS  = (SUM_BITS > 16) ? SUM_BITS : 16;

  localparam logic [TICKET_BITS-1:0] TICKET_MAX = '1;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_DRAW   = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  entry_index;
    logic [9:0]  new_tickets;
    logic        make_runnable;
    logic [15:0] draw_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  grant_index;
    logic [15:0] ticket_total;
    logic [31:0] grant_count;
  } rsp_t;

  typedef struct packed {
    logic                   runnable;
    logic [TICKET_BITS-1:0] tickets;
    logic [31:0]            count;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{runnable: 1'b0,
                                     tickets: TICKET_BITS'(1),
                                     count: 32'd0};

  typedef struct packed {
    logic                   cmd;
    logic                   upd_ok;
    logic [IDX_W-1:0]       idx;
    logic [TICKET_BITS-1:0] tickets;
    logic                   run;
    logic [15:0]            draw;
  } job_t;

endpackage

>>> hdl/ltp_cell.sv
module ltp_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  ltp_pkg::entry_t d,
  output ltp_pkg::entry_t q
);
  import ltp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= ENTRY_RESET;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

>>> hdl/ltp_head.sv
module ltp_head (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    shift,
  input  ltp_pkg::job_t           job,
  input  logic [ltp_pkg::IDX_W-1:0] pos,
  input  ltp_pkg::entry_t         head,
  output ltp_pkg::entry_t         tail,
  output ltp_pkg::rsp_t           res
);
  import ltp_pkg::*;

  logic [CMP_BITS-1:0] sum, sum_next;
  logic                found, found_next;
  logic [IDX_W-1:0]    win_idx, win_idx_next;
  logic [31:0]         win_count, win_count_next;

  always_comb begin
    tail           = head;
    sum_next       = sum;
    found_next     = found;
    win_idx_next   = win_idx;
    win_count_next = win_count;
    if (job.cmd == CMD_UPDATE) begin
      if (job.upd_ok && pos == job.idx) begin
        tail.runnable = job.run;
        tail.tickets  = job.tickets;
      end
    end else if (head.runnable) begin
      sum_next = sum + CMP_BITS'(head.tickets);
      if (!found && sum_next >= CMP_BITS'(job.draw)) begin
        found_next     = 1'b1;
        win_idx_next   = pos;
        win_count_next = head.count + 32'd1;
        tail.count     = head.count + 32'd1;
      end
    end
  end

  always_comb begin
    res = '0;
    if (job.cmd == CMD_UPDATE) begin
      res.status = job.upd_ok ? ST_OK : ST_REJECT;
    end else begin
      res.ticket_total = (sum_next > CMP_BITS'(16'hFFFF)) ? 16'hFFFF : sum_next[15:0];
      if (found_next) begin
        res.status      = ST_OK;
        res.grant_index = 6'(win_idx_next);
        res.grant_count = win_count_next;
      end else begin
        res.status = ST_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (start) begin
      found <= 1'b0;
      sum   <= '0;
    end else if (shift) begin
      found     <= found_next;
      sum       <= sum_next;
      win_idx   <= win_idx_next;
      win_count <= win_count_next;
    end
  end

endmodule

>>> hdl/lottery_ticket_picker.sv
// channel | valid     | stall     | payload
// --------+-----------+-----------+------------------------------
// request | req_valid | req_stall | req (cmd, index, tickets, draw)
// result  | rsp_valid | rsp_stall | rsp (status, grant, total, count)
//
// Each item takes one full turn of the entry table, a ring of cells that
// rotates one entry per cycle, bar the stall on its last step, past a single
// head unit that applies an update or accumulates tickets to pick a draw winner.
// Reset (rst, synchronous) loads every cell at once; no clearing pass.
// A new item is taken while a result still waits in the output register; the
// ring holds on its last step while that register is full and stalled.
module lottery_ticket_picker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ltp_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ltp_pkg::rsp_t  rsp
);
  import ltp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] cnt;
  job_t             job;
  entry_t           chain [ENTRIES];
  entry_t           tail;
  rsp_t             res;
  logic             accept, last, out_free, shift, done;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign last      = (cnt == IDX_W'(ENTRIES - 1));
  assign out_free  = !rsp_valid || !rsp_stall;
  assign shift     = (state == S_WALK) && (!last || out_free);
  assign done      = shift && last;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == ENTRIES - 1) begin : g_end
      ltp_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(tail), .q(chain[i]));
    end else begin : g_mid
      ltp_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(chain[i+1]), .q(chain[i]));
    end
  end

  ltp_head u_head (
    .clk  (clk),
    .rst  (rst),
    .start(accept),
    .shift(shift),
    .job  (job),
    .pos  (cnt),
    .head (chain[0]),
    .tail (tail),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      job.cmd     <= req.cmd;
      job.upd_ok  <= (req.new_tickets != 10'd0) && (32'(req.entry_index) < ENTRIES);
      job.idx     <= IDX_W'(req.entry_index);
      job.tickets <= (32'(req.new_tickets) > 32'(TICKET_MAX)) ? TICKET_MAX
                                                              : TICKET_BITS'(req.new_tickets);
      job.run     <= req.make_runnable;
      job.draw    <= req.draw_value;
    end
    if (done) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_WALK;
            cnt   <= '0;
          end
        end
        S_WALK: begin
          if (shift) begin
            cnt <= last ? '0 : cnt + IDX_W'(1);
            if (last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (done) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_idle_cnt: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> cnt == '0)
    else $error("walk counter not parked while idle");

  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_WALK && cnt == '0)
    else $error("accepted item did not start a walk");

  a_rsp_from_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_WALK && last))
    else $error("result raised outside the end of a walk");

  a_ring_still: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !shift)
    else $error("ring rotated while idle");

endmodule
